>>> sv/smx_pkg.sv
`default_nettype none

package smx_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int PC_BITS_DEF     = 16;

    localparam int WORD_W  = 32;
    localparam int PC_W    = 16;
    localparam int DEPTH_W = 9;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_JUMP  = 4'd4,
        OP_JZ    = 4'd5,
        OP_LOAD  = 4'd6,
        OP_STORE = 4'd7,
        OP_CONV  = 4'd8,
        OP_AUTH  = 4'd9,
        OP_END   = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        FAULT_NONE     = 3'd0,
        FAULT_UNDER    = 3'd1,
        FAULT_OVER     = 3'd2,
        FAULT_BAD_IDX  = 3'd3,
        FAULT_BAD_JUMP = 3'd4
    } fault_t;

    typedef enum logic [1:0] {
        CALL_NONE   = 2'd0,
        CALL_CONV   = 2'd1,
        CALL_VERIFY = 2'd2
    } call_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [WORD_W-1:0] operand;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic                     halted;
        fault_t                   fault;
        call_t                    call_request;
    } result_t;

endpackage

`default_nettype wire

>>> sv/smx_stack_ram.sv
`default_nettype none

module smx_stack_ram #(
    parameter int DEPTH     = smx_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_BITS = $clog2(smx_pkg::STACK_DEPTH_DEF)
) (
    input  wire logic                        clk,
    input  wire logic                        re,
    input  wire logic [ADDR_BITS-1:0]        raddr,
    output logic [smx_pkg::WORD_W-1:0]       rdata,
    input  wire logic                        we,
    input  wire logic [ADDR_BITS-1:0]        waddr,
    input  wire logic [smx_pkg::WORD_W-1:0]  wdata
);

    logic [smx_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/smx_core.sv
`default_nettype none

module smx_core #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = smx_pkg::PC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            issue,
    input  wire smx_pkg::instr_t issue_item,
    input  wire smx_pkg::instr_t exec_item,
    input  wire logic            retire,
    output smx_pkg::result_t     result
);

    localparam int SP_BITS   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_BITS = $clog2(STACK_DEPTH);
    localparam logic [32:0] PC_MAX = (33'd1 << PC_BITS) - 33'd1;

    logic [SP_BITS-1:0]         sp_reg,   sp_next;
    logic [PC_BITS-1:0]         pc_reg,   pc_next;
    logic                       halt_reg, halt_next;
    logic [smx_pkg::WORD_W-1:0] tos_reg,  tos_next;

    logic [SP_BITS-1:0]         sp_m2;
    logic [PC_BITS-1:0]         pc_inc;
    logic [ADDR_BITS-1:0]       raddr;
    logic [smx_pkg::WORD_W-1:0] rdata;
    logic                       we;
    logic [ADDR_BITS-1:0]       waddr;
    logic [smx_pkg::WORD_W-1:0] wdata;
    logic [smx_pkg::WORD_W-1:0] sum;
    logic [32:0]                idx_ext;
    logic [32:0]                sp_ext;
    logic                       full;
    logic                       empty;
    logic                       target_ok;
    logic                       tos_zero;
    smx_pkg::fault_t            fault;
    smx_pkg::call_t             call;
    logic [31:0]                pc_wide;
    logic [15:0]                depth_wide;

    assign sp_m2 = sp_reg - SP_BITS'(2);

    // second entry for pop/add/sub/jz/store, indexed entry for load
    always_comb
    begin
        if (issue_item.operation == smx_pkg::OP_LOAD)
        begin
            raddr = issue_item.operand[ADDR_BITS-1:0];
        end
        else
        begin
            raddr = sp_m2[ADDR_BITS-1:0];
        end
    end

    smx_stack_ram #(
        .DEPTH     (STACK_DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata)
    );

    assign pc_inc    = pc_reg + PC_BITS'(1);
    assign idx_ext   = {1'b0, exec_item.operand};
    assign sp_ext    = 33'(sp_reg);
    assign full      = (sp_reg == SP_BITS'(STACK_DEPTH));
    assign empty     = (sp_reg == '0);
    assign target_ok = !exec_item.operand[31] && (idx_ext <= PC_MAX);
    assign tos_zero  = (tos_reg == '0);
    assign sum       = (exec_item.operation == smx_pkg::OP_ADD) ? rdata + tos_reg
                                                               : rdata - tos_reg;

    always_comb
    begin
        sp_next   = sp_reg;
        tos_next  = tos_reg;
        pc_next   = pc_inc;
        halt_next = halt_reg;
        fault     = smx_pkg::FAULT_NONE;
        call      = smx_pkg::CALL_NONE;
        we        = 1'b0;
        waddr     = sp_reg[ADDR_BITS-1:0];
        wdata     = exec_item.operand;

        if (halt_reg)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            case (exec_item.operation)
                smx_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        fault = smx_pkg::FAULT_OVER;
                    end
                    else
                    begin
                        we       = 1'b1;
                        tos_next = exec_item.operand;
                        sp_next  = sp_reg + SP_BITS'(1);
                    end
                end
                smx_pkg::OP_POP:
                begin
                    if (empty)
                    begin
                        fault = smx_pkg::FAULT_UNDER;
                    end
                    else
                    begin
                        tos_next = rdata;
                        sp_next  = sp_reg - SP_BITS'(1);
                    end
                end
                smx_pkg::OP_ADD, smx_pkg::OP_SUB:
                begin
                    if (sp_reg < SP_BITS'(2))
                    begin
                        fault = smx_pkg::FAULT_UNDER;
                    end
                    else
                    begin
                        we       = 1'b1;
                        waddr    = sp_m2[ADDR_BITS-1:0];
                        wdata    = sum;
                        tos_next = sum;
                        sp_next  = sp_reg - SP_BITS'(1);
                    end
                end
                smx_pkg::OP_JUMP:
                begin
                    if (!target_ok)
                    begin
                        fault = smx_pkg::FAULT_BAD_JUMP;
                    end
                    else
                    begin
                        pc_next = exec_item.operand[PC_BITS-1:0];
                    end
                end
                smx_pkg::OP_JZ:
                begin
                    if (empty)
                    begin
                        fault = smx_pkg::FAULT_UNDER;
                    end
                    else if (tos_zero && !target_ok)
                    begin
                        fault = smx_pkg::FAULT_BAD_JUMP;
                    end
                    else
                    begin
                        tos_next = rdata;
                        sp_next  = sp_reg - SP_BITS'(1);
                        if (tos_zero)
                        begin
                            pc_next = exec_item.operand[PC_BITS-1:0];
                        end
                    end
                end
                smx_pkg::OP_LOAD:
                begin
                    if (full)
                    begin
                        fault = smx_pkg::FAULT_OVER;
                    end
                    else if (!(idx_ext < sp_ext))
                    begin
                        fault = smx_pkg::FAULT_BAD_IDX;
                    end
                    else
                    begin
                        we       = 1'b1;
                        wdata    = rdata;
                        tos_next = rdata;
                        sp_next  = sp_reg + SP_BITS'(1);
                    end
                end
                smx_pkg::OP_STORE:
                begin
                    if (empty)
                    begin
                        fault = smx_pkg::FAULT_UNDER;
                    end
                    else if (!(idx_ext < sp_ext - 33'd1))
                    begin
                        fault = smx_pkg::FAULT_BAD_IDX;
                    end
                    else
                    begin
                        we      = 1'b1;
                        waddr   = exec_item.operand[ADDR_BITS-1:0];
                        wdata   = tos_reg;
                        sp_next = sp_reg - SP_BITS'(1);
                        // storing into the new top: the old top moves down
                        if (exec_item.operand[ADDR_BITS-1:0] != sp_m2[ADDR_BITS-1:0])
                        begin
                            tos_next = rdata;
                        end
                    end
                end
                smx_pkg::OP_CONV:
                begin
                    call = smx_pkg::CALL_CONV;
                end
                smx_pkg::OP_AUTH:
                begin
                    call = smx_pkg::CALL_VERIFY;
                end
                smx_pkg::OP_END:
                begin
                    halt_next = 1'b1;
                end
                default:
                begin
                    fault = smx_pkg::FAULT_NONE;
                end
            endcase
        end

        if (!retire)
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            pc_reg   <= '0;
            halt_reg <= 1'b0;
            tos_reg  <= '0;
        end
        else if (retire)
        begin
            sp_reg   <= sp_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            tos_reg  <= tos_next;
        end
    end

    assign pc_wide    = 32'(pc_next);
    assign depth_wide = 16'(sp_next);

    always_comb
    begin
        result.next_pc      = pc_wide[smx_pkg::PC_W-1:0];
        result.top_value    = (sp_next == '0) ? '0 : tos_next;
        result.depth        = depth_wide[smx_pkg::DEPTH_W-1:0];
        result.halted       = halt_next;
        result.fault        = fault;
        result.call_request = call;
    end

endmodule

`default_nettype wire

>>> sv/stack_machine_executor.sv
// Channel  | Signals                              | Word
// ---------+--------------------------------------+------------------------
// instr    | instr_valid, instr_stall, instr      | operation, operand
// result   | result_valid, result_stall, result   | pc, top, depth, status
//
// An instruction takes two cycles: the accept edge issues the stack RAM read,
// the next edge executes, writes the RAM and loads the output register.
// One instruction every two cycles: the next read must wait for the stack pointer
// and RAM write of the instruction in execute.
// A new instruction is taken while a finished result waits in the output register.
// Reset clears stack pointer, program counter and halt flag; RAM needs no clearing
// pass since only entries below the stack pointer are ever used.
// A stalled result holds the execute stage, which in turn stalls instr.
`default_nettype none

module stack_machine_executor #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = smx_pkg::PC_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             instr_valid,
    output logic                  instr_stall,
    input  wire smx_pkg::instr_t  instr,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output smx_pkg::result_t      result
);

    logic             exec_valid_reg;
    smx_pkg::instr_t  exec_item_reg;
    logic             out_valid_reg;
    smx_pkg::result_t out_reg;
    logic             issue;
    logic             retire;
    smx_pkg::result_t core_result;

    assign instr_stall = exec_valid_reg;
    assign issue       = instr_valid && !exec_valid_reg;
    assign retire      = exec_valid_reg && (!out_valid_reg || !result_stall);

    smx_core #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_BITS     (PC_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_item (instr),
        .exec_item  (exec_item_reg),
        .retire     (retire),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                exec_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                exec_valid_reg <= 1'b0;
            end

            if (retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            exec_item_reg <= instr;
        end
        if (retire)
        begin
            out_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

>>> sv/smx_checker.sv
`default_nettype none

module smx_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             instr_valid,
    input wire logic             instr_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire smx_pkg::result_t result
);

    // a waiting result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // execute stage is busy the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid && !instr_stall |=> instr_stall)
        else $error("instr accepted on consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.halted |->
            result.fault == smx_pkg::FAULT_NONE &&
            result.call_request == smx_pkg::CALL_NONE)
        else $error("halted result carries fault or call");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.depth == '0 |-> result.top_value == '0)
        else $error("empty stack shows nonzero top");

endmodule

bind stack_machine_executor smx_checker u_smx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

>>> tb/tb.sv
module tb;

    localparam int STACK_WORDS  = smx_pkg::STACK_DEPTH_DEF;
    localparam int WORD_W       = smx_pkg::WORD_W;
    localparam int PC_W         = smx_pkg::PC_W;
    localparam int DEPTH_W      = smx_pkg::DEPTH_W;
    localparam int RANDOM_ITEMS = 800;
    localparam int FILL_AT      = 300;
    localparam int QUIET_AT     = 700;
    localparam int CHUNK        = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             instr_valid  = 1'b0;
    logic             instr_stall;
    smx_pkg::instr_t  instr        = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    smx_pkg::result_t result;

    // Machine state as the predictor sees it
    logic [WORD_W-1:0] stack_mem [STACK_WORDS];
    int                stack_sp;
    logic [PC_W-1:0]   pc_q;
    logic              halt_q;

    smx_pkg::instr_t  queued_instrs[$];
    smx_pkg::result_t predicted_results[$];

    bit failed;
    bit quiet;
    bit word_taken;
    int idle_left;
    int stall_left;

    always #5 clk = ~clk;

    stack_machine_executor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    function automatic bit jump_target_ok(logic signed [WORD_W-1:0] t);
        return t >= 0 && t <= (1 << PC_W) - 1;
    endfunction

    task automatic execute_instr(input smx_pkg::instr_t w, output smx_pkg::result_t r);
        logic [PC_W-1:0]   npc;
        smx_pkg::fault_t   f;
        smx_pkg::call_t    c;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        bit                zero;
        int                idx;
        npc = pc_q + PC_W'(1);
        f   = smx_pkg::FAULT_NONE;
        c   = smx_pkg::CALL_NONE;
        idx = w.operand;
        if (halt_q)
        begin
            npc = pc_q;
        end
        else
        begin
            case (w.operation)
                smx_pkg::OP_PUSH:
                begin
                    if (stack_sp >= STACK_WORDS)
                        f = smx_pkg::FAULT_OVER;
                    else
                    begin
                        stack_mem[stack_sp] = w.operand;
                        stack_sp++;
                    end
                end
                smx_pkg::OP_POP:
                begin
                    if (stack_sp == 0)
                        f = smx_pkg::FAULT_UNDER;
                    else
                        stack_sp--;
                end
                smx_pkg::OP_ADD, smx_pkg::OP_SUB:
                begin
                    if (stack_sp < 2)
                        f = smx_pkg::FAULT_UNDER;
                    else
                    begin
                        b = stack_mem[stack_sp-1];
                        a = stack_mem[stack_sp-2];
                        stack_mem[stack_sp-2] = (w.operation == smx_pkg::OP_ADD) ? a + b
                                                                                 : a - b;
                        stack_sp--;
                    end
                end
                smx_pkg::OP_JUMP:
                begin
                    if (!jump_target_ok(w.operand))
                        f = smx_pkg::FAULT_BAD_JUMP;
                    else
                        npc = w.operand[PC_W-1:0];
                end
                smx_pkg::OP_JZ:
                begin
                    if (stack_sp == 0)
                        f = smx_pkg::FAULT_UNDER;
                    else
                    begin
                        zero = stack_mem[stack_sp-1] == '0;
                        // a bad target only matters when the jump would be taken
                        if (zero && !jump_target_ok(w.operand))
                            f = smx_pkg::FAULT_BAD_JUMP;
                        else
                        begin
                            stack_sp--;
                            if (zero)
                                npc = w.operand[PC_W-1:0];
                        end
                    end
                end
                smx_pkg::OP_LOAD:
                begin
                    if (stack_sp >= STACK_WORDS)
                        f = smx_pkg::FAULT_OVER;
                    else if (idx < 0 || idx >= stack_sp)
                        f = smx_pkg::FAULT_BAD_IDX;
                    else
                    begin
                        stack_mem[stack_sp] = stack_mem[idx];
                        stack_sp++;
                    end
                end
                smx_pkg::OP_STORE:
                begin
                    if (stack_sp == 0)
                        f = smx_pkg::FAULT_UNDER;
                    else if (idx < 0 || idx >= stack_sp - 1)
                        f = smx_pkg::FAULT_BAD_IDX;
                    else
                    begin
                        stack_mem[idx] = stack_mem[stack_sp-1];
                        stack_sp--;
                    end
                end
                smx_pkg::OP_CONV:
                    c = smx_pkg::CALL_CONV;
                smx_pkg::OP_AUTH:
                    c = smx_pkg::CALL_VERIFY;
                smx_pkg::OP_END:
                    halt_q = 1'b1;
                default:
                    ;
            endcase
            pc_q = npc;
        end
        r.next_pc      = pc_q;
        r.top_value    = (stack_sp > 0) ? stack_mem[stack_sp-1] : '0;
        r.depth        = DEPTH_W'(stack_sp);
        r.halted       = halt_q;
        r.fault        = f;
        r.call_request = c;
    endtask

    function automatic smx_pkg::instr_t word_of(smx_pkg::op_t op, logic [WORD_W-1:0] val);
        smx_pkg::instr_t w;
        w.operation = op;
        w.operand   = val;
        return w;
    endfunction

    // Operands lean toward values that get past the fault checks at depth est
    function automatic smx_pkg::instr_t random_instr(int est);
        int                pick;
        smx_pkg::op_t      op;
        logic [WORD_W-1:0] val;
        pick = $urandom_range(0, 99);
        val  = $urandom;
        if (pick < 22)
            op = smx_pkg::OP_PUSH;
        else if (pick < 30)
            op = smx_pkg::OP_POP;
        else if (pick < 38)
            op = smx_pkg::OP_ADD;
        else if (pick < 46)
            op = smx_pkg::OP_SUB;
        else if (pick < 54)
            op = smx_pkg::OP_JUMP;
        else if (pick < 64)
            op = smx_pkg::OP_JZ;
        else if (pick < 74)
            op = smx_pkg::OP_LOAD;
        else if (pick < 82)
            op = smx_pkg::OP_STORE;
        else if (pick < 88)
            op = smx_pkg::OP_CONV;
        else if (pick < 94)
            op = smx_pkg::OP_AUTH;
        else
            op = smx_pkg::op_t'(4'($urandom_range(11, 15)));
        case (op)
            smx_pkg::OP_PUSH:
            begin
                case ($urandom_range(0, 7))
                    0, 1: val = '0;
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0: val = 32'h7FFF_FFFF;
                            1: val = 32'h8000_0000;
                            2: val = 32'hFFFF_FFFF;
                            default: val = 32'h1;
                        endcase
                    end
                    default: ;
                endcase
            end
            smx_pkg::OP_JUMP, smx_pkg::OP_JZ:
            begin
                case ($urandom_range(0, 9))
                    0: ;
                    1:
                    begin
                        if ($urandom_range(0, 1) != 0)
                            val = 32'h1_0000 + $urandom_range(0, 255);
                        else
                            val = ~32'($urandom_range(0, 255));
                    end
                    default: val = $urandom_range(0, (1 << PC_W) - 1);
                endcase
            end
            smx_pkg::OP_LOAD:
            begin
                if ($urandom_range(0, 9) != 0)
                    val = $urandom_range(0, est);
            end
            smx_pkg::OP_STORE:
            begin
                if ($urandom_range(0, 9) != 0)
                    val = $urandom_range(0, (est > 1) ? est - 1 : 0);
            end
            default: ;
        endcase
        return word_of(op, val);
    endfunction

    function automatic int next_depth_guess(smx_pkg::instr_t w, int est);
        case (w.operation)
            smx_pkg::OP_PUSH, smx_pkg::OP_LOAD:
                return (est < STACK_WORDS) ? est + 1 : est;
            smx_pkg::OP_POP, smx_pkg::OP_JZ, smx_pkg::OP_STORE:
                return (est > 0) ? est - 1 : est;
            smx_pkg::OP_ADD, smx_pkg::OP_SUB:
                return (est >= 2) ? est - 1 : est;
            default:
                return est;
        endcase
    endfunction

    task automatic wait_all_done();
        while (queued_instrs.size() != 0 || instr_valid || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
        if (exp !== act)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
            failed = 1'b1;
        end
    endtask

    // Instruction driver: predict the word taken at the last rising edge, then advance
    always @(negedge clk)
    begin : drive_instr
        bit               took;
        smx_pkg::result_t r;
        took       = word_taken;
        word_taken = 1'b0;
        if (took)
        begin
            execute_instr(instr, r);
            predicted_results.push_back(r);
        end
        if (!instr_valid || took)
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                instr_valid <= 1'b0;
            end
            else if (queued_instrs.size() > 0)
            begin
                instr       <= queued_instrs.pop_front();
                instr_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    idle_left = $urandom_range(1, 6);
            end
            else
            begin
                instr_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : watch_ports
        smx_pkg::result_t e;
        if (rst_n)
        begin
            if (instr_valid && !instr_stall)
                word_taken = 1'b1;
            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result word with no instruction pending, next_pc 0x%0h",
                           result.next_pc);
                    failed = 1'b1;
                end
                else
                begin
                    e = predicted_results.pop_front();
                    check_field("next_pc", 32'(e.next_pc), 32'(result.next_pc));
                    check_field("top_value", e.top_value, result.top_value);
                    check_field("depth", 32'(e.depth), 32'(result.depth));
                    check_field("halted", 32'(e.halted), 32'(result.halted));
                    check_field("fault", 32'(e.fault), 32'(result.fault));
                    check_field("call_request", 32'(e.call_request),
                                32'(result.call_request));
                end
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[stack_machine_executor] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int              n;
        int              est;
        bit              filled;
        smx_pkg::instr_t w;
        foreach (stack_mem[i])
            stack_mem[i] = '0;
        stack_sp = 0;
        pc_q     = '0;
        halt_q   = 1'b0;
        filled   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty-stack faults first, then wraps, index and jump edge cases, calls and unused opcodes
        queued_instrs.push_back(word_of(smx_pkg::OP_POP, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_ADD, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_JZ, 32'h5));
        queued_instrs.push_back(word_of(smx_pkg::OP_STORE, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_LOAD, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_PUSH, 32'h7FFF_FFFF));
        queued_instrs.push_back(word_of(smx_pkg::OP_PUSH, 32'h1));
        queued_instrs.push_back(word_of(smx_pkg::OP_ADD, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_PUSH, 32'h1));
        queued_instrs.push_back(word_of(smx_pkg::OP_SUB, 32'hFFFF_FFFF));
        queued_instrs.push_back(word_of(smx_pkg::OP_LOAD, 32'hFFFF_FFFF));
        queued_instrs.push_back(word_of(smx_pkg::OP_LOAD, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_STORE, 32'h5));
        queued_instrs.push_back(word_of(smx_pkg::OP_STORE, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_JUMP, 32'hFFFF_FFFF));
        queued_instrs.push_back(word_of(smx_pkg::OP_JUMP, 32'h1_0000));
        queued_instrs.push_back(word_of(smx_pkg::OP_JUMP, 32'hFFFF));
        queued_instrs.push_back(word_of(smx_pkg::OP_CONV, 32'h8000_0000));
        queued_instrs.push_back(word_of(smx_pkg::OP_AUTH, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_PUSH, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_JZ, 32'h8000_0000));
        queued_instrs.push_back(word_of(smx_pkg::OP_JZ, 32'h64));
        queued_instrs.push_back(word_of(smx_pkg::OP_PUSH, 32'h5));
        queued_instrs.push_back(word_of(smx_pkg::OP_JZ, 32'hFFFF_FFFF));
        queued_instrs.push_back(word_of(smx_pkg::op_t'(4'd15), 32'hFFFF_FFFF));
        queued_instrs.push_back(word_of(smx_pkg::op_t'(4'd11), 32'h0));

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            while (queued_instrs.size() != 0)
                @(posedge clk);
            if (n >= QUIET_AT)
                quiet = 1'b1;
            if (!filled && n >= FILL_AT)
            begin
                // Hold off until the block drains, then fill the stack past full
                wait_all_done();
                est = stack_sp;
                repeat (STACK_WORDS - est + 2)
                begin
                    queued_instrs.push_back(word_of(smx_pkg::OP_PUSH, $urandom));
                    n++;
                end
                queued_instrs.push_back(word_of(smx_pkg::OP_LOAD, 32'h0));
                n++;
                filled = 1'b1;
            end
            est = stack_sp;
            repeat (CHUNK)
            begin
                w   = random_instr(est);
                est = next_depth_guess(w, est);
                queued_instrs.push_back(w);
                n++;
            end
        end

        // Halt, then confirm that later words change nothing
        queued_instrs.push_back(word_of(smx_pkg::OP_END, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_PUSH, 32'h5));
        queued_instrs.push_back(word_of(smx_pkg::OP_POP, 32'h0));
        queued_instrs.push_back(word_of(smx_pkg::OP_JUMP, 32'h3));
        queued_instrs.push_back(word_of(smx_pkg::OP_CONV, 32'h0));

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && predicted_results.size() == 0)
            $display("[stack_machine_executor] OK");
        else
            $display("[stack_machine_executor] ERROR");
        $finish;
    end
endmodule

>>> sim.f
sv/smx_pkg.sv
sv/smx_stack_ram.sv
sv/smx_core.sv
sv/stack_machine_executor.sv
sv/smx_checker.sv
tb/tb.sv
